// ===== rtl/lfk_pkg.sv =====
// Shared constants, types and the arctangent table for the leg forward kinematics core.
// Used by lfk_cordic, lfk_foot and leg_forward_kinematics_core; depends on nothing.
package lfk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ITER = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CORDIC_LAT = ITER + 3;
  localparam int FOOT_LAT = CORDIC_LAT + 4;

  localparam int JW = 16;
  localparam int GW = 18;
  localparam int ASH = 17;
  localparam int AW = GW + ASH + 1;
  localparam int CW = 32;
  localparam int EW = 11;
  localparam int LNW = 16;
  localparam int PW = 42;
  localparam int OW = 18;
  localparam int DW = EW + 4;
  localparam int NW = PW + 2;
  localparam int QB = OW;
  localparam int RW = DW + QB;
  localparam int CIW = 3;

  localparam logic CMD_POS = 1'b0;
  localparam logic CMD_JAC = 1'b1;

  localparam logic [1:0] PART_POS = 2'd0;
  localparam logic [1:0] PART_HIP = 2'd1;
  localparam logic [1:0] PART_THIGH = 2'd2;
  localparam logic [1:0] PART_CALF = 2'd3;

  localparam logic [CIW-1:0] REG_STEP = 3'd0;
  localparam logic [CIW-1:0] REG_LATERAL = 3'd1;
  localparam logic [CIW-1:0] REG_THIGH = 3'd2;
  localparam logic [CIW-1:0] REG_CALF = 3'd3;
  localparam logic [CIW-1:0] REG_FWD = 3'd4;
  localparam logic [CIW-1:0] REG_SIDE = 3'd5;

  localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

  typedef struct packed {
    logic [LNW-1:0] lateral;
    logic [LNW-1:0] thigh;
    logic [LNW-1:0] calf;
    logic [LNW-1:0] fwd;
    logic [LNW-1:0] side;
  } geom_t;

  typedef struct packed {
    logic          v;
    logic          cmd;
    logic [1:0]    part;
    logic          last;
    logic [EW-1:0] e;
  } meta_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 36'sd843314856;
      1: r = 36'sd497837829;
      2: r = 36'sd263043836;
      3: r = 36'sd133525158;
      4: r = 36'sd67021686;
      5: r = 36'sd33543515;
      6: r = 36'sd16775850;
      7: r = 36'sd8388437;
      8: r = 36'sd4194282;
      9: r = 36'sd2097149;
      10: r = 36'sd1048575;
      11: r = 36'sd524287;
      12: r = 36'sd262143;
      13: r = 36'sd131071;
      14: r = 36'sd65535;
      15: r = 36'sd32767;
      16: r = 36'sd16383;
      17: r = 36'sd8191;
      18: r = 36'sd4095;
      19: r = 36'sd2047;
      20: r = 36'sd1023;
      21: r = 36'sd511;
      22: r = 36'sd255;
      23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lfk_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of one joint angle.
// Depends on lfk_pkg for widths, step count and the arctangent table.
module lfk_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [lfk_pkg::GW-1:0] angle,
  output logic signed [lfk_pkg::CW-1:0] sin_o,
  output logic signed [lfk_pkg::CW-1:0] cos_o
);
  import lfk_pkg::*;

  logic signed [AW-1:0] a_wide;
  logic signed [AW-1:0] a_red_nxt;
  logic signed [AW-1:0] a_red_r;
  logic signed [AW-1:0] a_fold_nxt;
  logic                 flip_nxt;
  logic signed [AW-1:0] a_r [0:ITER];
  logic signed [CW-1:0] x_r [0:ITER];
  logic signed [CW-1:0] y_r [0:ITER];
  logic                 flip_r [0:ITER];
  logic signed [CW-1:0] sin_r;
  logic signed [CW-1:0] cos_r;

  assign a_wide = {{(AW-GW-ASH){angle[GW-1]}}, angle, {ASH{1'b0}}};

  always_comb begin
    if (a_wide > PI_Q30) begin
      a_red_nxt = a_wide - TWO_PI_Q30;
    end else if (a_wide < -PI_Q30) begin
      a_red_nxt = a_wide + TWO_PI_Q30;
    end else begin
      a_red_nxt = a_wide;
    end
  end

  always_comb begin
    if (a_red_r > HALF_PI_Q30) begin
      a_fold_nxt = a_red_r - PI_Q30;
      flip_nxt = 1'b1;
    end else if (a_red_r < -HALF_PI_Q30) begin
      a_fold_nxt = a_red_r + PI_Q30;
      flip_nxt = 1'b1;
    end else begin
      a_fold_nxt = a_red_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_red_r <= a_red_nxt;
    end
  end

  for (genvar i = 0; i <= ITER; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[0] <= a_fold_nxt;
          x_r[0] <= GAIN_Q30;
          y_r[0] <= '0;
          flip_r[0] <= flip_nxt;
        end
      end
    end else begin : g_iter
      always_ff @(posedge clk) begin
        if (en) begin
          if (!a_r[i-1][AW-1]) begin
            x_r[i] <= x_r[i-1] - (y_r[i-1] >>> (i-1));
            y_r[i] <= y_r[i-1] + (x_r[i-1] >>> (i-1));
            a_r[i] <= a_r[i-1] - atan_q30(i-1);
          end else begin
            x_r[i] <= x_r[i-1] + (y_r[i-1] >>> (i-1));
            y_r[i] <= y_r[i-1] - (x_r[i-1] >>> (i-1));
            a_r[i] <= a_r[i-1] + atan_q30(i-1);
          end
          flip_r[i] <= flip_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= flip_r[ITER] ? -y_r[ITER] : y_r[ITER];
      cos_r <= flip_r[ITER] ? -x_r[ITER] : x_r[ITER];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== rtl/lfk_foot.sv =====
// Foot position pipeline: three CORDICs, link products and the hip rotation.
// Depends on lfk_pkg and instantiates lfk_cordic.
module lfk_foot (
  input  logic                          clk,
  input  logic                          en,
  input  logic [1:0]                    leg,
  input  logic signed [lfk_pkg::GW-1:0] ang_hip,
  input  logic signed [lfk_pkg::GW-1:0] ang_thigh,
  input  logic signed [lfk_pkg::GW-1:0] ang_sum,
  input  lfk_pkg::geom_t                geom,
  output logic signed [lfk_pkg::PW-1:0] p_x,
  output logic signed [lfk_pkg::PW-1:0] p_y,
  output logic signed [lfk_pkg::PW-1:0] p_z
);
  import lfk_pkg::*;

  localparam int SLW = LNW + 1;
  localparam int LPW = CW + SLW;
  localparam int LSW = LPW + 2;
  localparam int ZW = LSW - 22;
  localparam int XRW = LSW - 14;
  localparam int OFW = SLW + 16;
  localparam int YW = SLW + 8;
  localparam int MW = CW + ZW;
  localparam int RSW = MW + 1;

  logic signed [CW-1:0] sh, ch, st, ct, sk, ck;
  logic [1:0] leg_r [0:CORDIC_LAT];

  logic signed [LPW-1:0] m_ts_r, m_cs_r, m_tc_r, m_cc_r;
  logic signed [CW-1:0]  sh1_r, ch1_r;

  logic signed [LSW-1:0] vx, vz, vx_rnd, vz_rnd;
  logic signed [SLW-1:0] fx, fy, lat;
  logic signed [PW-1:0]  p0_nxt;
  logic signed [ZW-1:0]  vz24_nxt;
  logic signed [YW-1:0]  vy24_nxt;
  logic signed [OFW-1:0] fyt_nxt;

  logic signed [PW-1:0]  p0_2_r;
  logic signed [ZW-1:0]  vz24_r;
  logic signed [YW-1:0]  vy24_r;
  logic signed [OFW-1:0] fyt_2_r;
  logic signed [CW-1:0]  sh2_r, ch2_r;

  logic signed [MW-1:0]  ma_r, mb_r, mc_r, md_r;
  logic signed [PW-1:0]  p0_3_r;
  logic signed [OFW-1:0] fyt_3_r;

  logic signed [RSW-1:0] ry, rz;
  logic signed [PW-1:0]  px_r, py_r, pz_r;

  lfk_cordic u_cordic_hip (.clk(clk), .en(en), .angle(ang_hip), .sin_o(sh), .cos_o(ch));
  lfk_cordic u_cordic_thigh (.clk(clk), .en(en), .angle(ang_thigh), .sin_o(st), .cos_o(ct));
  lfk_cordic u_cordic_sum (.clk(clk), .en(en), .angle(ang_sum), .sin_o(sk), .cos_o(ck));

  always_ff @(posedge clk) begin
    if (en) begin
      leg_r[0] <= leg;
      for (int i = 1; i <= CORDIC_LAT; i++) begin
        leg_r[i] <= leg_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ts_r <= $signed({1'b0, geom.thigh}) * st;
      m_tc_r <= $signed({1'b0, geom.thigh}) * ct;
      m_cs_r <= $signed({1'b0, geom.calf}) * sk;
      m_cc_r <= $signed({1'b0, geom.calf}) * ck;
      sh1_r <= sh;
      ch1_r <= ch;
    end
  end

  always_comb begin
    vx = -(LSW'(m_ts_r) + LSW'(m_cs_r));
    vz = -(LSW'(m_tc_r) + LSW'(m_cc_r));
    vx_rnd = vx + (LSW'(1) <<< 13);
    vz_rnd = vz + (LSW'(1) <<< 21);
    fx = leg_r[CORDIC_LAT][1] ? -$signed({1'b0, geom.fwd}) : $signed({1'b0, geom.fwd});
    fy = leg_r[CORDIC_LAT][0] ? -$signed({1'b0, geom.side}) : $signed({1'b0, geom.side});
    lat = leg_r[CORDIC_LAT][0] ? -$signed({1'b0, geom.lateral})
                               : $signed({1'b0, geom.lateral});
    vz24_nxt = $signed(vz_rnd[LSW-1:22]);
    vy24_nxt = $signed({lat, 8'b0});
    fyt_nxt = $signed({fy, 16'b0});
    p0_nxt = PW'($signed({fx, 16'b0})) + PW'($signed(vx_rnd[LSW-1:14]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_2_r <= p0_nxt;
      vz24_r <= vz24_nxt;
      vy24_r <= vy24_nxt;
      fyt_2_r <= fyt_nxt;
      sh2_r <= sh1_r;
      ch2_r <= ch1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= MW'(ch2_r * vy24_r);
      mb_r <= sh2_r * vz24_r;
      mc_r <= MW'(sh2_r * vy24_r);
      md_r <= ch2_r * vz24_r;
      p0_3_r <= p0_2_r;
      fyt_3_r <= fyt_2_r;
    end
  end

  always_comb begin
    ry = RSW'(ma_r) - RSW'(mb_r) + (RSW'(1) <<< 21);
    rz = RSW'(mc_r) + RSW'(md_r) + (RSW'(1) <<< 21);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= p0_3_r;
      py_r <= PW'(fyt_3_r) + PW'($signed(ry[RSW-1:22]));
      pz_r <= PW'($signed(rz[RSW-1:22]));
    end
  end

  assign p_x = px_r;
  assign p_y = py_r;
  assign p_z = pz_r;

endmodule

// ===== rtl/leg_forward_kinematics_core.sv =====
// Leg forward kinematics core: foot position or finite-difference jacobian per beat.
// Depends on lfk_pkg and instantiates two lfk_foot pipelines.
//
// A position request gives one result beat and the block takes one input beat per cycle
// while the output is not stalled; a jacobian request gives three column beats (hip,
// thigh, calf) and occupies the issue stage for all three columns, since each column needs
// one pass through the pair of foot pipelines (one at the angle plus the step, one at the
// angle minus the step). Results pass through the CORDIC stages, four stages of link and
// hip rotation arithmetic, and a pipelined divider that scales each difference by the step.
// A stalled output holds the whole pipeline; configuration registers are to be written
// only while idle, which the block itself does not enforce.
module leg_forward_kinematics_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [1:0]                     in_leg,
  input  logic signed [lfk_pkg::JW-1:0]  in_hip_angle,
  input  logic signed [lfk_pkg::JW-1:0]  in_thigh_angle,
  input  logic signed [lfk_pkg::JW-1:0]  in_calf_angle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_part,
  output logic signed [lfk_pkg::OW-1:0]  out_x,
  output logic signed [lfk_pkg::OW-1:0]  out_y,
  output logic signed [lfk_pkg::OW-1:0]  out_z,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [lfk_pkg::CIW-1:0]        cfg_index,
  input  logic [lfk_pkg::LNW-1:0]        cfg_data
);
  import lfk_pkg::*;

  localparam int RPW = PW - 16;
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic                   v;
    logic                   cmd;
    logic [1:0]             part;
    logic                   last;
    logic [DW-1:0]          den;
    logic [2:0]             neg;
    logic [2:0][NW-1:0]     n;
    logic [2:0][OW-1:0]     pos;
  } post_t;

  typedef struct packed {
    logic                   v;
    logic                   cmd;
    logic [1:0]             part;
    logic                   last;
    logic [DW-1:0]          den;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QB-1:0]     q;
    logic [2:0][OW-1:0]     pos;
  } div_t;

  logic adv;
  logic accept;
  logic final_issue;

  logic [EW-1:0]  step_r;
  geom_t          geom_r;

  logic                 busy_r;
  logic                 cmd_r;
  logic [1:0]           leg_r;
  logic [1:0]           col_r;
  logic signed [JW-1:0] h_r, t_r, k_r;

  logic [EW-1:0]        e_eff;
  logic signed [GW-1:0] dh, dt, dk, hx, tx, kx;

  meta_t                job_meta_r;
  logic [1:0]           job_leg_r;
  logic signed [GW-1:0] jhp_r, jtp_r, jsp_r, jhm_r, jtm_r, jsm_r;
  meta_t                meta_r [0:FOOT_LAT-1];

  logic signed [PW-1:0] pp [0:2];
  logic signed [PW-1:0] pm [0:2];

  post_t post_nxt, post_r;
  div_t  div_nxt [0:QB];
  div_t  div_r [0:QB];

  logic signed [PW:0]    dif;
  logic [PW:0]           mag;
  logic signed [PW-1:0]  prnd;
  logic signed [RPW-1:0] pr;
  logic [RW-1:0]         sub;
  logic [OW-1:0]         res [0:2];

  logic                  out_valid_r;
  logic [1:0]            out_part_r;
  logic                  out_last_r;
  logic signed [OW-1:0]  out_x_r, out_y_r, out_z_r;

  assign adv = !out_valid_r || out_ready;
  assign final_issue = (cmd_r == CMD_POS) || (col_r == PART_CALF);
  assign in_ready = adv && (!busy_r || final_issue);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 11'd8;
      geom_r.lateral <= 16'd5574;
      geom_r.thigh <= 16'd13959;
      geom_r.calf <= 16'd13959;
      geom_r.fwd <= 16'd12675;
      geom_r.side <= 16'd3047;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP: step_r <= cfg_data[EW-1:0];
        REG_LATERAL: geom_r.lateral <= cfg_data;
        REG_THIGH: geom_r.thigh <= cfg_data;
        REG_CALF: geom_r.calf <= cfg_data;
        REG_FWD: geom_r.fwd <= cfg_data;
        REG_SIDE: geom_r.side <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r <= PART_POS;
    end else if (accept) begin
      busy_r <= 1'b1;
      col_r <= (in_command == CMD_JAC) ? PART_HIP : PART_POS;
    end else if (busy_r && adv) begin
      if (final_issue) begin
        busy_r <= 1'b0;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      leg_r <= in_leg;
      h_r <= in_hip_angle;
      t_r <= in_thigh_angle;
      k_r <= in_calf_angle;
    end
  end

  always_comb begin
    e_eff = (step_r == '0) ? EW'(1) : step_r;
    dh = (col_r == PART_HIP) ? $signed(GW'(e_eff)) : '0;
    dt = (col_r == PART_THIGH) ? $signed(GW'(e_eff)) : '0;
    dk = (col_r == PART_CALF) ? $signed(GW'(e_eff)) : '0;
    hx = GW'(h_r);
    tx = GW'(t_r);
    kx = GW'(k_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_meta_r <= '0;
    end else if (adv) begin
      job_meta_r.v <= busy_r;
      job_meta_r.cmd <= cmd_r;
      job_meta_r.part <= col_r;
      job_meta_r.last <= final_issue;
      job_meta_r.e <= e_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_leg_r <= leg_r;
      jhp_r <= hx + dh;
      jtp_r <= tx + dt;
      jsp_r <= (tx + dt) + (kx + dk);
      jhm_r <= hx - dh;
      jtm_r <= tx - dt;
      jsm_r <= (tx - dt) + (kx - dk);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FOOT_LAT; i++) begin
        meta_r[i] <= '0;
      end
    end else if (adv) begin
      meta_r[0] <= job_meta_r;
      for (int i = 1; i < FOOT_LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  lfk_foot u_foot_plus (
    .clk(clk), .en(adv), .leg(job_leg_r),
    .ang_hip(jhp_r), .ang_thigh(jtp_r), .ang_sum(jsp_r), .geom(geom_r),
    .p_x(pp[0]), .p_y(pp[1]), .p_z(pp[2])
  );

  lfk_foot u_foot_minus (
    .clk(clk), .en(adv), .leg(job_leg_r),
    .ang_hip(jhm_r), .ang_thigh(jtm_r), .ang_sum(jsm_r), .geom(geom_r),
    .p_x(pm[0]), .p_y(pm[1]), .p_z(pm[2])
  );

  always_comb begin
    post_nxt.v = meta_r[FOOT_LAT-1].v;
    post_nxt.cmd = meta_r[FOOT_LAT-1].cmd;
    post_nxt.part = meta_r[FOOT_LAT-1].part;
    post_nxt.last = meta_r[FOOT_LAT-1].last;
    post_nxt.den = {meta_r[FOOT_LAT-1].e, 4'b0};
    for (int a = 0; a < 3; a++) begin
      dif = (PW+1)'(pp[a]) - (PW+1)'(pm[a]);
      mag = dif[PW] ? -dif : dif;
      post_nxt.neg[a] = dif[PW];
      post_nxt.n[a] = NW'(mag) + NW'({meta_r[FOOT_LAT-1].e, 3'b0});
      prnd = pp[a] + (PW'(1) <<< 15);
      pr = $signed(prnd[PW-1:16]);
      if (pr > RPW'(OUT_MAX)) begin
        post_nxt.pos[a] = OUT_MAX;
      end else if (pr < RPW'(OUT_MIN)) begin
        post_nxt.pos[a] = OUT_MIN;
      end else begin
        post_nxt.pos[a] = pr[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r.v <= 1'b0;
    end else if (adv) begin
      post_r <= post_nxt;
    end
  end

  always_comb begin
    div_nxt[0].v = post_r.v;
    div_nxt[0].cmd = post_r.cmd;
    div_nxt[0].part = post_r.part;
    div_nxt[0].last = post_r.last;
    div_nxt[0].den = post_r.den;
    div_nxt[0].neg = post_r.neg;
    div_nxt[0].pos = post_r.pos;
    for (int a = 0; a < 3; a++) begin
      div_nxt[0].ovf[a] = post_r.n[a] >= NW'({post_r.den, {QB{1'b0}}});
      div_nxt[0].rem[a] = post_r.n[a][RW-1:0];
      div_nxt[0].q[a] = '0;
    end
    for (int j = 0; j < QB; j++) begin
      div_nxt[j+1] = div_r[j];
      for (int a = 0; a < 3; a++) begin
        sub = RW'(div_r[j].den) << (QB-1-j);
        if (div_r[j].rem[a] >= sub) begin
          div_nxt[j+1].rem[a] = div_r[j].rem[a] - sub;
          div_nxt[j+1].q[a][QB-1-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) begin
        div_r[j].v <= 1'b0;
      end
    end else if (adv) begin
      for (int j = 0; j <= QB; j++) begin
        div_r[j] <= div_nxt[j];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (div_r[QB].cmd == CMD_POS) begin
        res[a] = div_r[QB].pos[a];
      end else if (div_r[QB].neg[a]) begin
        if (div_r[QB].ovf[a] || (div_r[QB].q[a][QB-1] && |div_r[QB].q[a][QB-2:0])) begin
          res[a] = OUT_MIN;
        end else begin
          res[a] = -div_r[QB].q[a];
        end
      end else begin
        if (div_r[QB].ovf[a] || div_r[QB].q[a][QB-1]) begin
          res[a] = OUT_MAX;
        end else begin
          res[a] = div_r[QB].q[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_r[QB].v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_part_r <= div_r[QB].part;
      out_last_r <= div_r[QB].last;
      out_x_r <= res[0];
      out_y_r <= res[1];
      out_z_r <= res[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_part = out_part_r;
  assign out_last = out_last_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_z = out_z_r;

`ifndef SYNTHESIS
  a_jac_col: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cmd_r == CMD_JAC |-> col_r != PART_POS)
    else $error("Jacobian item is issuing without a column.");

  a_pos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_part_r == PART_POS |-> out_last_r)
    else $error("Position beat is not marked last.");

  a_jac_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && out_part_r != PART_POS |-> out_part_r == PART_CALF)
    else $error("Jacobian ends on a column other than the calf.");
`endif

endmodule
